FILE: sv/usbrx_pkg.sv
`timescale 1ns / 1ps

package usbrx_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int OP_W   = 3;
  localparam int ARM_W  = 2;
  localparam int CNT_W  = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_DATA    = 3'd0,
    OP_PKT_END = 3'd1,
    OP_READ    = 3'd2,
    OP_BUS_RST = 3'd3,
    OP_CONFIG  = 3'd4,
    OP_OPEN    = 3'd5,
    OP_CLOSE   = 3'd6
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: sv/usbrx_ctrl.sv
`timescale 1ns / 1ps

module usbrx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output usbrx_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state_r;
  logic   exec_r;
  logic   out_valid_r;
  logic   load;

  // no beat is taken while reset is held
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign load      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cmd.load  = load;
  assign cmd.exec  = exec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exec_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (load) begin
            state_r <= S_EXEC;
            exec_r  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_r     <= S_OUT;
          exec_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          exec_r      <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cmd.exec)
    else $error("accepted beat not executed");
  a_exec_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid && in_stall)
    else $error("executed beat not presented");
  a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("exec held for more than one cycle");
`endif

endmodule

FILE: sv/usbrx_dp.sv
`timescale 1ns / 1ps

module usbrx_dp #(
  parameter int BUFFERS      = 4,
  parameter int PACKET_BYTES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  usbrx_pkg::cmd_t                  cmd,
  input  logic [usbrx_pkg::OP_W-1:0]       in_operation,
  input  logic [usbrx_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [usbrx_pkg::LEN_W-1:0]      in_packet_length,
  input  logic                             in_packet_error,
  input  logic                             cfg_wr_en,
  input  logic [usbrx_pkg::LEN_W-1:0]      cfg_wr_data,
  output logic [usbrx_pkg::BYTE_W-1:0]     out_read_data,
  output logic                             out_read_ok,
  output logic                             out_arm_receive,
  output logic [usbrx_pkg::ARM_W-1:0]      out_arm_buffer,
  output logic                             out_data_ready,
  output logic                             out_tx_enable,
  output logic                             out_queue_full,
  output logic [usbrx_pkg::CNT_W-1:0]      out_full_events
);

  localparam int IDX_W  = $clog2(BUFFERS);
  localparam int DEPTH  = BUFFERS * PACKET_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CAP    = (PACKET_BYTES < 127) ? PACKET_BYTES : 127;
  localparam logic [usbrx_pkg::LEN_W-1:0] CAP_L = usbrx_pkg::LEN_W'(CAP);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFERS - 1);

  typedef logic [usbrx_pkg::LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0]            idx_t;

  function automatic idx_t ring_inc(input idx_t i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // captured beat
  usbrx_pkg::op_t                 op_r;
  logic [usbrx_pkg::BYTE_W-1:0]   byte_r;
  len_t                           plen_r;
  logic                           perr_r;

  // ring state
  len_t                           max_len_r;
  len_t                           pkt_len_r [BUFFERS];
  len_t                           pkt_len_nxt [BUFFERS];
  len_t                           rd_pos_r [BUFFERS];
  len_t                           rd_pos_nxt [BUFFERS];
  idx_t                           head_r, head_nxt;
  idx_t                           tail_r, tail_nxt;
  logic                           full_r, full_nxt;
  logic                           cfgd_r, cfgd_nxt;
  logic                           tx_en_r, tx_en_nxt;
  len_t                           wr_off_r, wr_off_nxt;
  logic [usbrx_pkg::CNT_W-1:0]    full_cnt_r, full_cnt_nxt;

  // per-beat results
  logic                           rok_r, rok_nxt;
  logic                           arm_r, arm_nxt;
  idx_t                           arm_buf_r, arm_buf_nxt;
  logic                           ready_r, ready_nxt;

  logic [usbrx_pkg::BYTE_W-1:0]   mem [DEPTH];
  logic [usbrx_pkg::BYTE_W-1:0]   mem_q_r;
  logic                           mem_we;
  logic                           mem_re;
  logic [ADDR_W-1:0]              wr_addr;
  logic [ADDR_W-1:0]              rd_addr;

  len_t eff_max;
  len_t rd_pos_inc;
  idx_t head_inc;
  idx_t tail_inc;

  assign eff_max    = (max_len_r == '0) ? len_t'(1) :
                      ((max_len_r > CAP_L) ? CAP_L : max_len_r);
  assign rd_pos_inc = rd_pos_r[tail_r] + 1'b1;
  assign head_inc   = ring_inc(head_r);
  assign tail_inc   = ring_inc(tail_r);
  assign wr_addr    = ADDR_W'(int'(head_r) * PACKET_BYTES + int'(wr_off_r));
  assign rd_addr    = ADDR_W'(int'(tail_r) * PACKET_BYTES + int'(rd_pos_r[tail_r]));

  always_comb begin
    pkt_len_nxt  = pkt_len_r;
    rd_pos_nxt   = rd_pos_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    full_nxt     = full_r;
    cfgd_nxt     = cfgd_r;
    tx_en_nxt    = tx_en_r;
    wr_off_nxt   = wr_off_r;
    full_cnt_nxt = full_cnt_r;
    rok_nxt      = rok_r;
    arm_nxt      = arm_r;
    arm_buf_nxt  = arm_buf_r;
    ready_nxt    = ready_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    if (cmd.exec) begin
      rok_nxt     = 1'b0;
      arm_nxt     = 1'b0;
      arm_buf_nxt = '0;
      ready_nxt   = 1'b0;
      unique case (op_r)
        usbrx_pkg::OP_DATA: begin
          if (cfgd_r && !full_r && (wr_off_r < eff_max)) begin
            mem_we     = 1'b1;
            wr_off_nxt = wr_off_r + 1'b1;
          end
        end
        usbrx_pkg::OP_PKT_END: begin
          if (cfgd_r) begin
            tx_en_nxt = 1'b1;
            if (!full_r) begin
              if (perr_r || (plen_r == '0)) begin
                // failed or empty packet: re-arm the same buffer
                arm_nxt     = 1'b1;
                arm_buf_nxt = head_r;
                wr_off_nxt  = '0;
              end else begin
                pkt_len_nxt[head_r] = (plen_r > eff_max) ? eff_max : plen_r;
                rd_pos_nxt[head_r]  = '0;
                if (head_inc != tail_r) begin
                  head_nxt    = head_inc;
                  arm_nxt     = 1'b1;
                  arm_buf_nxt = head_inc;
                  wr_off_nxt  = '0;
                end else begin
                  full_nxt     = 1'b1;
                  full_cnt_nxt = full_cnt_r + 1'b1;
                end
                ready_nxt = 1'b1;
              end
            end
          end
        end
        usbrx_pkg::OP_READ: begin
          if (tail_r != head_r) begin
            mem_re             = 1'b1;
            rok_nxt            = 1'b1;
            rd_pos_nxt[tail_r] = rd_pos_inc;
            if (rd_pos_inc >= pkt_len_r[tail_r]) begin
              // buffer drained: free it, resume reception if stuck full
              tail_nxt = tail_inc;
              if (full_r) begin
                full_nxt    = 1'b0;
                head_nxt    = head_inc;
                arm_nxt     = 1'b1;
                arm_buf_nxt = head_inc;
                wr_off_nxt  = '0;
              end
            end
          end
        end
        usbrx_pkg::OP_BUS_RST: begin
          cfgd_nxt = 1'b0;
        end
        usbrx_pkg::OP_CONFIG: begin
          if (!full_r) begin
            arm_nxt     = 1'b1;
            arm_buf_nxt = head_r;
            wr_off_nxt  = '0;
          end
          cfgd_nxt = 1'b1;
        end
        usbrx_pkg::OP_OPEN: begin
          if (cfgd_r) tx_en_nxt = 1'b1;
        end
        usbrx_pkg::OP_CLOSE: begin
          if (cfgd_r) tx_en_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= usbrx_pkg::op_t'(in_operation);
      byte_r <= in_data_byte;
      plen_r <= in_packet_length;
      perr_r <= in_packet_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= usbrx_pkg::MAX_LEN_RESET;
      pkt_len_r  <= '{default: '0};
      rd_pos_r   <= '{default: '0};
      head_r     <= '0;
      tail_r     <= '0;
      full_r     <= 1'b0;
      cfgd_r     <= 1'b0;
      tx_en_r    <= 1'b0;
      wr_off_r   <= '0;
      full_cnt_r <= '0;
      rok_r      <= 1'b0;
      arm_r      <= 1'b0;
      arm_buf_r  <= '0;
      ready_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      pkt_len_r  <= pkt_len_nxt;
      rd_pos_r   <= rd_pos_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      full_r     <= full_nxt;
      cfgd_r     <= cfgd_nxt;
      tx_en_r    <= tx_en_nxt;
      wr_off_r   <= wr_off_nxt;
      full_cnt_r <= full_cnt_nxt;
      rok_r      <= rok_nxt;
      arm_r      <= arm_nxt;
      arm_buf_r  <= arm_buf_nxt;
      ready_r    <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= byte_r;
    if (mem_re) mem_q_r <= mem[rd_addr];
  end

  assign out_read_data   = rok_r ? mem_q_r : '0;
  assign out_read_ok     = rok_r;
  assign out_arm_receive = arm_r;
  assign out_arm_buffer  = usbrx_pkg::ARM_W'(arm_buf_r);
  assign out_data_ready  = ready_r;
  assign out_tx_enable   = tx_en_r;
  assign out_queue_full  = full_r;
  assign out_full_events = full_cnt_r;

`ifndef SYNTH
  a_full_means_ring_closed: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (head_inc == tail_r))
    else $error("full flag set while a buffer is free");
  a_full_counted: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> (full_cnt_r != $past(full_cnt_r)))
    else $error("full condition not counted");
  a_tail_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_r != $past(tail_r)) |-> $past(cmd.exec))
    else $error("tail moved outside an executed beat");
`endif

endmodule

FILE: sv/usb_rx_packet_ring_buffer_core.sv
`timescale 1ns / 1ps

// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall   | operation, data_byte, packet_length, packet_error
// out_    | output    | out_valid / out_stall | read_data, read_ok, arm_receive, arm_buffer,
//         |           |                       | data_ready, tx_enable, queue_full, full_events
// cfg_    | input     | cfg_wr_en             | cfg_wr_data (max packet length)
//
// each beat passes through three steps: capture, execute, present
// the execute cycle reads the packet byte memory, whose registered output feeds read_data
// a new beat is taken only once the previous result has been taken
// synchronous active-low reset clears all ring state; packet bytes are not cleared
// out_stall holds the result and keeps in_stall high

module usb_rx_packet_ring_buffer_core #(
  parameter int BUFFERS      = 4,
  parameter int PACKET_BYTES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [usbrx_pkg::OP_W-1:0]   in_operation,
  input  logic [usbrx_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [usbrx_pkg::LEN_W-1:0]  in_packet_length,
  input  logic                         in_packet_error,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [usbrx_pkg::BYTE_W-1:0] out_read_data,
  output logic                         out_read_ok,
  output logic                         out_arm_receive,
  output logic [usbrx_pkg::ARM_W-1:0]  out_arm_buffer,
  output logic                         out_data_ready,
  output logic                         out_tx_enable,
  output logic                         out_queue_full,
  output logic [usbrx_pkg::CNT_W-1:0]  out_full_events,
  input  logic                         cfg_wr_en,
  input  logic [usbrx_pkg::LEN_W-1:0]  cfg_wr_data
);

  usbrx_pkg::cmd_t cmd;

  usbrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  usbrx_dp #(
    .BUFFERS      (BUFFERS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_operation),
    .in_data_byte     (in_data_byte),
    .in_packet_length (in_packet_length),
    .in_packet_error  (in_packet_error),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_read_data    (out_read_data),
    .out_read_ok      (out_read_ok),
    .out_arm_receive  (out_arm_receive),
    .out_arm_buffer   (out_arm_buffer),
    .out_data_ready   (out_data_ready),
    .out_tx_enable    (out_tx_enable),
    .out_queue_full   (out_queue_full),
    .out_full_events  (out_full_events)
  );

endmodule
